>>> sv/fmic_pkg.sv
// ----------------------------------------------------------------------------
// fmic_pkg
// Shared types and codes for the FM interval transition cache.
// ----------------------------------------------------------------------------
package fmic_pkg;

    localparam logic [1:0] REQ_QUERY  = 2'd0;
    localparam logic [1:0] REQ_FILL   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CFG_TEXT_LENGTH = 2'd0;
    localparam logic [1:0] CFG_DIVISOR     = 2'd1;
    localparam logic [1:0] CFG_MIN_WIDTH   = 2'd2;

    localparam int unsigned CFG_W = 32;
    localparam int unsigned SYM_W = 8;

    // divider control between top level and the shared divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

>>> sv/fmic_ram.sv
// ----------------------------------------------------------------------------
// fmic_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module fmic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> sv/fmic_div.sv
// ----------------------------------------------------------------------------
// fmic_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmic_div #(
    parameter int W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [W-1:0]           i_num,
    input  logic [W-1:0]           i_den,
    output fmic_pkg::t_div_ctl     o_ctl,
    output logic [W-1:0]           o_quo,
    output logic [W-1:0]           o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den, n_den;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_cnt  = CW'(W);
            n_busy = 1'b1;
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = (i_den == '0) ? W'(1) : i_den;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quo = r_quo;
    assign o_rem = r_rem;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("div done without busy");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_den)) else $error("div remainder too large");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("div restarted while busy");
`endif
endmodule

>>> sv/fm_interval_transition_cache.sv
// ----------------------------------------------------------------------------
// fm_interval_transition_cache
// Set-associative cache of FM-index backward-search steps with hit/miss
// counters, bucket chosen by the left bound divided by a configured divisor.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | dir
//  request   | i_valid/o_ready, i_req_type..i_new_right | in
//  result    | o_valid/i_ready, o_hit..o_entry_total    | out
//  config    | i_cfg_we, i_cfg_index, i_cfg_data        | in
//
//  From accept to result valid a word goes at most through two passes of
//  the shared bit-serial divider (old_left, then text_length), the range
//  check and fill count read, one read per way for a query or the slot
//  write for a fill, and S_OUT to raise valid.
//  A clear sweeps the whole bucket fill memory; after reset the same
//  sweep runs before the first word is taken. The result register holds
//  until taken; no new word is accepted meanwhile.
// ----------------------------------------------------------------------------
module fm_interval_transition_cache #(
    parameter int NUM_BUCKETS = 1024,
    parameter int WAYS        = 4,
    parameter int POS_BITS    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_req_type,
    input  logic [POS_BITS-1:0]      i_old_left,
    input  logic [POS_BITS-1:0]      i_old_right,
    input  logic [7:0]               i_symbol,
    input  logic [POS_BITS-1:0]      i_new_left,
    input  logic [POS_BITS-1:0]      i_new_right,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_hit,
    output logic                     o_bypass,
    output logic [POS_BITS-1:0]      o_result_left,
    output logic [POS_BITS-1:0]      o_result_right,
    output logic [1:0]               o_status,
    output logic [31:0]              o_hit_total,
    output logic [31:0]              o_miss_total,
    output logic [12:0]              o_entry_total,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data
);
    localparam int SLOTS  = NUM_BUCKETS * WAYS;
    localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW     = $clog2(WAYS + 1);
    localparam int PW     = POS_BITS;
    localparam int KW     = 2 * PW + 8;
    localparam int VW     = 2 * PW;
    localparam int DW     = (PW > 32) ? PW : 32;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DIV1   = 10'b0000000100,
        S_DIV2W  = 10'b0000001000,
        S_DIV2   = 10'b0000010000,
        S_CHECK  = 10'b0000100000,
        S_FILLRD = 10'b0001000000,
        S_WAY    = 10'b0010000000,
        S_WRITE  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0]   r_text_len, r_divisor, r_min_width;
    logic [1:0]    r_req;
    logic [PW-1:0] r_ol, r_or, r_nl, r_nr;
    logic [7:0]    r_sym;
    logic [DW-1:0] r_bucket, n_bucket;
    logic [DW-1:0] r_rem, n_rem;
    logic [BW-1:0] r_clr, n_clr;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_way, n_way;
    logic          r_rdwait, n_rdwait;
    logic          r_clear_req, n_clear_req;

    logic          r_ovalid, n_ovalid;
    logic          r_hit, n_hit, r_byp, n_byp;
    logic [PW-1:0] r_rl, n_rl, r_rr, n_rr;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_hits, n_hits, r_misses, n_misses;
    logic [12:0]   r_entries, n_entries;

    // divider
    logic               w_div_start;
    logic [DW-1:0]      w_div_num;
    fmic_pkg::t_div_ctl w_div_ctl;
    logic [DW-1:0]      w_quo, w_drem;

    fmic_div #(.W(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (DW'(r_divisor)),
        .o_ctl  (w_div_ctl),
        .o_quo  (w_quo),
        .o_rem  (w_drem)
    );

    // memories
    logic          w_fill_we;
    logic [BW-1:0] w_fill_addr;
    logic [FW-1:0] w_fill_wdata, w_fill_rdata;
    logic          w_slot_we;
    logic [SW-1:0] w_slot_addr;
    logic [KW-1:0] w_key_rdata;
    logic [VW-1:0] w_val_rdata;

    fmic_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .i_clk(i_clk), .i_we(w_fill_we), .i_addr(w_fill_addr),
        .i_wdata(w_fill_wdata), .o_rdata(w_fill_rdata)
    );
    fmic_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key_ram (
        .i_clk(i_clk), .i_we(w_slot_we), .i_addr(w_slot_addr),
        .i_wdata({r_rem[PW-1:0], r_or, r_sym}), .o_rdata(w_key_rdata)
    );
    fmic_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_val_ram (
        .i_clk(i_clk), .i_we(w_slot_we), .i_addr(w_slot_addr),
        .i_wdata({r_nl, r_nr}), .o_rdata(w_val_rdata)
    );

    logic [PW-1:0] w_width;
    logic          w_accept;
    logic [SW-1:0] w_base;
    logic          w_key_match;
    logic          w_range_bad;

    assign o_ready   = (r_state == S_IDLE) && !r_ovalid;
    assign w_accept  = i_valid && o_ready;
    assign w_width   = r_or - r_ol;
    assign w_base    = SW'(r_bucket[BW-1:0]) * SW'(WAYS);
    assign w_slot_addr = w_base + SW'(r_way[WW-1:0]);
    assign w_key_match = (w_key_rdata == {r_rem[PW-1:0], r_or, r_sym});
    // after second divide w_quo holds text_length / div
    assign w_range_bad = (r_bucket > w_quo) || (r_bucket >= DW'(NUM_BUCKETS));

    always_comb begin
        n_state     = r_state;
        n_bucket    = r_bucket;
        n_rem       = r_rem;
        n_clr       = r_clr;
        n_fill      = r_fill;
        n_way       = r_way;
        n_rdwait    = 1'b0;
        n_clear_req = r_clear_req;
        n_ovalid    = r_ovalid;
        n_hit       = r_hit;
        n_byp       = r_byp;
        n_rl        = r_rl;
        n_rr        = r_rr;
        n_status    = r_status;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_entries   = r_entries;
        w_div_start = 1'b0;
        w_div_num   = DW'(r_ol);
        w_fill_we   = 1'b0;
        w_fill_addr = r_bucket[BW-1:0];
        w_fill_wdata = r_fill + FW'(1);
        w_slot_we   = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_fill_we    = 1'b1;
                w_fill_addr  = r_clr;
                w_fill_wdata = '0;
                n_clr        = r_clr + BW'(1);
                if (r_clr == BW'(NUM_BUCKETS - 1)) begin
                    n_clr   = '0;
                    n_state = r_clear_req ? S_OUT : S_IDLE;
                    n_clear_req = 1'b0;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_hit = 1'b0; n_byp = 1'b0;
                    n_rl  = '0;   n_rr  = '0;
                    n_status = fmic_pkg::ST_OK;
                    case (i_req_type)
                        fmic_pkg::REQ_QUERY, fmic_pkg::REQ_FILL: n_state = S_DIV1;
                        fmic_pkg::REQ_CLEAR: begin
                            n_hits = '0; n_misses = '0; n_entries = '0;
                            n_clear_req = 1'b1;
                            n_state = S_CLEAR;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DIV1: begin
                if (!w_div_ctl.busy && !w_div_ctl.done && !r_rdwait) begin
                    w_div_start = 1'b1;
                    n_rdwait    = 1'b1;
                end else if (w_div_ctl.done) begin
                    n_bucket = w_quo;
                    n_rem    = w_drem;
                    n_state  = S_DIV2W;
                end else begin
                    n_rdwait = r_rdwait;
                end
            end
            S_DIV2W: begin
                w_div_start = 1'b1;
                w_div_num   = DW'(r_text_len);
                n_state     = S_DIV2;
            end
            S_DIV2: begin
                if (w_div_ctl.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_width <= PW'(r_min_width)) begin
                    n_byp   = 1'b1;
                    n_state = S_OUT;
                end else if (w_range_bad) begin
                    n_status = fmic_pkg::ST_RANGE;
                    n_state  = S_OUT;
                end else begin
                    n_state  = S_FILLRD;
                    n_rdwait = 1'b1;
                end
            end
            S_FILLRD: begin
                if (r_rdwait) begin
                    n_rdwait = 1'b0;
                end else begin
                    n_fill = w_fill_rdata;
                    n_way  = '0;
                    if (r_req == fmic_pkg::REQ_FILL) begin
                        if (r_nl == r_nr) begin
                            n_status = fmic_pkg::ST_EMPTY;
                            n_state  = S_OUT;
                        end else if (w_fill_rdata >= FW'(WAYS)) begin
                            n_status = fmic_pkg::ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_way   = w_fill_rdata;
                            n_state = S_WRITE;
                        end
                    end else if (w_fill_rdata == '0) begin
                        if (r_misses != '1) n_misses = r_misses + 32'd1;
                        n_state = S_OUT;
                    end else begin
                        n_state  = S_WAY;
                        n_rdwait = 1'b1;
                    end
                end
            end
            S_WAY: begin
                // one way per read: r_rdwait holds off the compare until the registered data is out
                if (r_rdwait) begin
                    n_rdwait = 1'b0;
                end else if (w_key_match) begin
                    n_hit = 1'b1;
                    n_rl  = w_val_rdata[VW-1:PW];
                    n_rr  = w_val_rdata[PW-1:0];
                    if (r_hits != '1) n_hits = r_hits + 32'd1;
                    n_state = S_OUT;
                end else if (r_way + FW'(1) >= r_fill) begin
                    if (r_misses != '1) n_misses = r_misses + 32'd1;
                    n_state = S_OUT;
                end else begin
                    n_way    = r_way + FW'(1);
                    n_rdwait = 1'b1;
                end
            end
            S_WRITE: begin
                w_slot_we = 1'b1;
                w_fill_we = 1'b1;
                n_entries = r_entries + 13'd1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we && i_cfg_index <= fmic_pkg::CFG_MIN_WIDTH) begin
            n_hits = '0; n_misses = '0; n_entries = '0;
            n_state = S_CLEAR;
            n_clr   = '0;
            n_clear_req = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clear_req <= 1'b0;
            r_ovalid    <= 1'b0;
            r_rdwait    <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_entries   <= '0;
            r_text_len  <= 32'd1;
            r_divisor   <= 32'd4194304;
            r_min_width <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clear_req <= n_clear_req;
            r_ovalid    <= n_ovalid;
            r_rdwait    <= n_rdwait;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_entries   <= n_entries;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fmic_pkg::CFG_TEXT_LENGTH: r_text_len  <= i_cfg_data;
                    fmic_pkg::CFG_DIVISOR:     r_divisor   <= i_cfg_data;
                    fmic_pkg::CFG_MIN_WIDTH:   r_min_width <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (w_accept) begin
            r_req <= i_req_type;
            r_ol  <= i_old_left;
            r_or  <= i_old_right;
            r_sym <= i_symbol;
            r_nl  <= i_new_left;
            r_nr  <= i_new_right;
        end
        r_bucket <= n_bucket;
        r_rem    <= n_rem;
        r_fill   <= n_fill;
        r_way    <= n_way;
        r_hit    <= n_hit;
        r_byp    <= n_byp;
        r_rl     <= n_rl;
        r_rr     <= n_rr;
        r_status <= n_status;
    end

    assign o_valid        = r_ovalid;
    assign o_hit          = r_hit;
    assign o_bypass       = r_byp;
    assign o_result_left  = r_rl;
    assign o_result_right = r_rr;
    assign o_status       = r_status;
    assign o_hit_total    = r_hits;
    assign o_miss_total   = r_misses;
    assign o_entry_total  = r_entries;

`ifndef SYNTHESIS
    a_hit_not_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_hit && r_byp)) else $error("hit and bypass together");
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= 13'(SLOTS)) else $error("entry count overflow");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAY && n_hit && !r_hit && !i_cfg_we && r_hits != '1)
        |=> (r_hits == $past(r_hits) + 32'd1)) else $error("hit not counted");
`endif
endmodule

>>> tb/tb_fm_interval_transition_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fm_interval_transition_cache
// Self-checking bench for the FM interval transition cache. A directed table
// covers bypass, range, empty and full fills, hits and clears. Random phases
// under several register settings follow, with bursty requests, a stalling
// result side and one long hold-off. Every result word is checked against the
// table answer or an in-bench model of the buckets and counters.
// ----------------------------------------------------------------------------
module tb_fm_interval_transition_cache;

    localparam int NB    = 1024;
    localparam int NW    = 4;
    localparam int NSLOT = NB * NW;

    typedef struct packed {
        logic        hit;
        logic        bypass;
        logic [31:0] left;
        logic [31:0] right;
        logic [1:0]  status;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [12:0] entries;
    } t_answer;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] ol;
        logic [31:0] orr;
        logic [7:0]  sym;
        logic [31:0] nl;
        logic [31:0] nr;
    } t_req;

    typedef struct packed {
        t_req    rq;
        logic    known;
        t_answer ans;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_old_left = '0, i_old_right = '0, i_new_left = '0, i_new_right = '0;
    logic [7:0]  i_symbol = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_hit, o_bypass;
    logic [31:0] o_result_left, o_result_right, o_hit_total, o_miss_total;
    logic [1:0]  o_status;
    logic [12:0] o_entry_total;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    fm_interval_transition_cache dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // interval cache model
    logic [31:0] m_text_len, m_divisor, m_min_width;
    logic [31:0] m_key_off [NSLOT];
    logic [31:0] m_key_right [NSLOT];
    logic [7:0]  m_key_sym [NSLOT];
    logic [31:0] m_val_left [NSLOT];
    logic [31:0] m_val_right [NSLOT];
    int unsigned m_fill [NB];
    logic [31:0] m_hits, m_misses;
    logic [12:0] m_entries;

    t_answer expected_words[$];
    int      n_errors = 0;
    int      n_words = 0;
    int      n_hits_seen = 0;
    int      n_sent = 0;
    bit      hold_req = 1'b0;
    bit      calm = 1'b0;

    function automatic void wipe_cache();
        foreach (m_fill[b]) m_fill[b] = 0;
        m_hits = '0;
        m_misses = '0;
        m_entries = '0;
    endfunction

    function automatic t_answer lookup_step(t_req r);
        t_answer     a;
        logic [31:0] width, dv, bkt, rem, last_bkt;
        int unsigned base;
        bit          found;
        a = '0;
        if (r.req == fmic_pkg::REQ_CLEAR) begin
            wipe_cache();
        end else if (r.req == fmic_pkg::REQ_QUERY || r.req == fmic_pkg::REQ_FILL) begin
            width = r.orr - r.ol;
            dv = (m_divisor == 0) ? 32'd1 : m_divisor;
            bkt = r.ol / dv;
            rem = r.ol % dv;
            last_bkt = m_text_len / dv;
            if (width <= m_min_width) begin
                a.bypass = 1'b1;
            end else if (bkt > last_bkt || bkt >= NB) begin
                a.status = fmic_pkg::ST_RANGE;
            end else begin
                base = bkt * NW;
                if (r.req == fmic_pkg::REQ_QUERY) begin
                    found = 1'b0;
                    for (int w = 0; w < NW; w++) begin
                        if (!found && w < m_fill[bkt] && m_key_off[base+w] == rem &&
                            m_key_right[base+w] == r.orr && m_key_sym[base+w] == r.sym) begin
                            found = 1'b1;
                            a.left = m_val_left[base+w];
                            a.right = m_val_right[base+w];
                        end
                    end
                    if (found) begin
                        a.hit = 1'b1;
                        if (m_hits != '1) m_hits++;
                    end else if (m_misses != '1) begin
                        m_misses++;
                    end
                end else if (r.nl == r.nr) begin
                    a.status = fmic_pkg::ST_EMPTY;
                end else if (m_fill[bkt] >= NW) begin
                    a.status = fmic_pkg::ST_FULL;
                end else begin
                    base = base + m_fill[bkt];
                    m_key_off[base] = rem;
                    m_key_right[base] = r.orr;
                    m_key_sym[base] = r.sym;
                    m_val_left[base] = r.nl;
                    m_val_right[base] = r.nr;
                    m_fill[bkt]++;
                    m_entries++;
                end
            end
        end
        a.hits = m_hits;
        a.misses = m_misses;
        a.entries = m_entries;
        return a;
    endfunction

    // result side: stall pattern plus one long hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        bit hold_used;
        if (hold_req && !hold_used) begin
            hold_left = 400;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        got = '{o_hit, o_bypass, o_result_left, o_result_right, o_status,
                o_hit_total, o_miss_total, o_entry_total};
        if (i_rst_n && o_valid && i_ready) begin
            n_words++;
            if (got.hit) n_hits_seen++;
            if (expected_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result word %p", got);
            end else if (got !== expected_words[0]) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch word %0d: exp %p got %p", n_words,
                             expected_words[0], got);
                void'(expected_words.pop_front());
            end else begin
                void'(expected_words.pop_front());
            end
        end
    end

    // drive one word; valid stays up across back-to-back words
    task automatic send_word(t_req r, bit known, t_answer ans);
        t_answer p;
        i_valid <= 1'b1;
        i_req_type <= r.req;
        i_old_left <= r.ol;
        i_old_right <= r.orr;
        i_symbol <= r.sym;
        i_new_left <= r.nl;
        i_new_right <= r.nr;
        do @(posedge i_clk); while (!o_ready);
        p = lookup_step(r);
        expected_words.insert(expected_words.size(), known ? ans : p);
        n_sent++;
    endtask

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fmic_pkg::CFG_TEXT_LENGTH) m_text_len = val;
        else if (idx == fmic_pkg::CFG_DIVISOR) m_divisor = val;
        else m_min_width = val;
        wipe_cache();
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);   // let any clear sweep finish
    endtask

    function automatic t_req rnd_noise();
        t_req r;
        r.req = 2'($urandom_range(0, 3));
        r.ol = $urandom;
        r.orr = $urandom;
        r.sym = 8'($urandom);
        r.nl = $urandom;
        r.nr = $urandom;
        return r;
    endfunction

    task automatic random_phase(logic [31:0] tl, logic [31:0] dv, logic [31:0] mw, int n,
                                bit hold);
        t_req        pool[8];
        t_req        r;
        int          span, burst, pick;
        logic [31:0] de;
        drain();
        write_reg(fmic_pkg::CFG_TEXT_LENGTH, tl);
        write_reg(fmic_pkg::CFG_DIVISOR, dv);
        write_reg(fmic_pkg::CFG_MIN_WIDTH, mw);
        repeat (1100) @(posedge i_clk);
        if (hold) hold_req = 1'b1;
        de = (dv == 0) ? 32'd1 : dv;
        span = (de > 16) ? 48 : 3 * de;
        foreach (pool[k]) begin
            pool[k].ol = $urandom_range(0, span);
            pool[k].orr = pool[k].ol + $urandom_range(1, 40);
            pool[k].sym = 8'($urandom);
        end
        burst = 0;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                r = rnd_noise();
            end else if (pick < 13) begin
                r = '0;
                r.req = fmic_pkg::REQ_CLEAR;
            end else begin
                r = pool[$urandom_range(0, 7)];
                r.req = (pick < 60) ? fmic_pkg::REQ_QUERY : fmic_pkg::REQ_FILL;
                r.nl = $urandom;
                r.nr = ($urandom_range(0, 19) == 0) ? r.nl : $urandom;
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if (!calm) idle_gap($urandom_range(1, 6));
            end
            burst--;
            send_word(r, 1'b0, '0);
        end
    endtask

    initial begin
        t_row tab[$];
        m_text_len = 32'd1;
        m_divisor = 32'd4194304;
        m_min_width = '0;
        wipe_cache();

        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0},
                   1'b1, '{1'b0, 1'b1, 32'd0, 32'd0, fmic_pkg::ST_OK, 32'd0, 32'd0, 13'd0}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'd0, 32'd10, 8'd5, 32'd0, 32'd0},
                   1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_OK, 32'd0, 32'd1, 13'd0}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_FILL, 32'd0, 32'd10, 8'd5, 32'd9, 32'd9},
                   1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_EMPTY, 32'd0, 32'd1,
                   13'd0}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_FILL, 32'd0, 32'd10, 8'd5, 32'd3, 32'd7},
                   1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_OK, 32'd0, 32'd1, 13'd1}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'd0, 32'd10, 8'd5, 32'd0, 32'd0},
                   1'b1, '{1'b1, 1'b0, 32'd3, 32'd7, fmic_pkg::ST_OK, 32'd1, 32'd1, 13'd1}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'd0, 8'd0, 32'd0,
                   32'd0}, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_RANGE, 32'd1,
                   32'd1, 13'd1}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_UNUSED, 32'd1, 32'd9, 8'd1, 32'd1, 32'd2},
                   1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_OK, 32'd1, 32'd1, 13'd1}});
        for (int k = 0; k < 3; k++)
            tab.insert(tab.size(), '{'{fmic_pkg::REQ_FILL, 32'd100, 32'd200, 8'(k), 32'd1,
                       32'd2}, 1'b0, '0});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_FILL, 32'd100, 32'd200, 8'd9, 32'd1, 32'd2},
                   1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_FULL, 32'd1, 32'd1,
                   13'd4}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'h003F_FFFF, 32'hFFFF_FFFF, 8'hFF,
                   32'd0, 32'd0}, 1'b0, '0});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'd100, 32'd200, 8'd2, 32'd0,
                   32'd0}, 1'b0, '0});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_FILL, 32'd4194304, 32'd4194400, 8'd0,
                   32'hFFFF_FFFF, 32'd0}, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0,
                   fmic_pkg::ST_RANGE, 32'd2, 32'd2, 13'd4}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_CLEAR, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0},
                   1'b1, '0});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_FILL, 32'd0, 32'd10, 8'd5, 32'hFFFF_FFFF,
                   32'd0}, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, fmic_pkg::ST_OK, 32'd0, 32'd0,
                   13'd1}});
        tab.insert(tab.size(), '{'{fmic_pkg::REQ_QUERY, 32'd0, 32'd10, 8'd5, 32'd0, 32'd0},
                   1'b1, '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0, fmic_pkg::ST_OK, 32'd1, 32'd0,
                   13'd1}});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (tab[k]) send_word(tab[k].rq, tab[k].known, tab[k].ans);

        random_phase(32'd4095, 32'd4, 32'd0, 110, 1'b0);
        // long result hold-off with requests still flowing
        random_phase(32'hFFFF_FFFF, 32'd0, 32'd5, 110, 1'b1);
        hold_req = 1'b0;
        calm = 1'b1;
        random_phase(32'd1000, 32'hFFFF_FFFF, 32'd0, 100, 1'b0);
        calm = 1'b0;
        random_phase(32'd100, 32'd10, 32'hFFFF_FFFF, 60, 1'b0);
        random_phase(32'd5000, 32'd8, 32'd3, 150, 1'b0);

        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d request words, %0d result words checked, %0d hits",
                 n_sent, n_words, n_hits_seen);
        $display("five register settings incl. zero and max divisor, all-bypass width");
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
